// ----- hdl/ptd_pkg.sv -----
`default_nettype none

package ptd_pkg;

	// Default sizes of the payload fields.
	localparam int VERTEX_WIDTH_DEF = 64;
	localparam int COUNT_WIDTH_DEF  = 16;

	// Command and primitive kind codes.
	localparam int KIND_W = 4;
	localparam logic [KIND_W-1:0] KIND_TRI         = 4'd0;
	localparam logic [KIND_W-1:0] KIND_QUAD        = 4'd1;
	localparam logic [KIND_W-1:0] KIND_QUAD_HARD   = 4'd2;
	localparam logic [KIND_W-1:0] KIND_SMOKE_BLACK = 4'd3;
	localparam logic [KIND_W-1:0] KIND_SMOKE_WHITE = 4'd4;
	localparam logic [KIND_W-1:0] KIND_MOVIE       = 4'd5;
	localparam logic [KIND_W-1:0] KIND_POLYGON     = 4'd6;
	localparam logic [KIND_W-1:0] KIND_TRI_STRIP   = 4'd7;
	localparam logic [KIND_W-1:0] KIND_TRI_FAN     = 4'd8;
	localparam logic [KIND_W-1:0] KIND_QUAD_STRIP  = 4'd9;
	localparam logic [KIND_W-1:0] KIND_OTHER       = 4'd10;

	// Valence register.
	localparam int VALENCE_W = 8;
	localparam logic [VALENCE_W-1:0] VALENCE_RESET   = 8'd4;
	localparam logic [VALENCE_W-1:0] VALENCE_TRI_MAX = 8'd3;

	// A job holds at most four vertices (one quad).
	localparam int SLOTS   = 4;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int NVERT_W = $clog2(SLOTS + 1);

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Bit positions in the result tuser.
	localparam int OUT_TUSER_W = KIND_W + 1;
	localparam int EOP_BIT     = KIND_W;

	// Control part of one job handed from the front to the back.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [NVERT_W-1:0] n;
		logic               eop_last;
	} job_ctl_t;

	localparam int CTL_W = $bits(job_ctl_t);

endpackage

`default_nettype wire

// ----- hdl/ptd_front.sv -----
`default_nettype none

module ptd_front
	import ptd_pkg::*;
#(
	parameter int VERTEX_WIDTH = VERTEX_WIDTH_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [VALENCE_W-1:0]          cfg_data,
	input  wire logic                          accept,
	input  wire logic [KIND_W-1:0]             cmd,
	input  wire logic [VERTEX_WIDTH-1:0]       vertex,
	input  wire logic [COUNT_WIDTH-1:0]        vertex_count,
	output logic                               job_valid,
	output job_ctl_t                           job_ctl,
	output logic [SLOTS-1:0][VERTEX_WIDTH-1:0] job_verts
);

	localparam int CMP_W = (COUNT_WIDTH > VALENCE_W) ? COUNT_WIDTH : VALENCE_W;

	logic [VALENCE_W-1:0]    max_valence_q;
	logic [COUNT_WIDTH-1:0]  pos_q;
	logic [VERTEX_WIDTH-1:0] first_q;
	logic [VERTEX_WIDTH-1:0] prev_one_q;
	logic [VERTEX_WIDTH-1:0] prev_two_q;
	logic [VERTEX_WIDTH-1:0] prev_three_q;

	logic [COUNT_WIDTH:0]    pos_inc;
	logic                    is_end;
	logic                    keep_quads;
	logic                    split_poly;
	logic                    pos_ge2;
	logic                    pos_ge3;
	logic                    pos_mid;
	logic [VERTEX_WIDTH-1:0] first;
	logic                    emit_single;
	logic                    emit_fan;
	logic                    emit_strip;
	logic                    emit_qstrip;
	logic [KIND_W-1:0]       single_kind;

	assign cfg_ready = 1'b1;

	// Valence register; the user must write it only while the block is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_valence_q <= VALENCE_RESET;
		end else if (cfg_valid) begin
			max_valence_q <= cfg_data;
		end
	end

	// Position decode and choice of the primitive to emit.
	always_comb begin
		pos_inc     = {1'b0, pos_q} + (COUNT_WIDTH + 1)'(1);
		is_end      = pos_inc >= {1'b0, vertex_count};
		keep_quads  = max_valence_q > VALENCE_TRI_MAX;
		split_poly  = CMP_W'(max_valence_q) < CMP_W'(vertex_count);
		pos_ge2     = pos_q >= COUNT_WIDTH'(2);
		pos_ge3     = pos_q >= COUNT_WIDTH'(3);
		pos_mid     = (pos_q == COUNT_WIDTH'(2)) || (pos_q == COUNT_WIDTH'(3));
		first       = (pos_q == '0) ? vertex : first_q;
		emit_single = 1'b0;
		emit_fan    = 1'b0;
		emit_strip  = 1'b0;
		emit_qstrip = 1'b0;
		single_kind = cmd;
		unique case (cmd)
			KIND_QUAD, KIND_QUAD_HARD, KIND_SMOKE_BLACK, KIND_SMOKE_WHITE,
			KIND_MOVIE: begin
				if (keep_quads) begin
					emit_single = 1'b1;
					single_kind = KIND_QUAD;
				end else begin
					emit_fan = pos_mid;
				end
			end
			KIND_POLYGON: begin
				if (split_poly) begin
					emit_fan = pos_ge2;
				end else begin
					emit_single = 1'b1;
				end
			end
			KIND_TRI_FAN: begin
				emit_fan = pos_ge2;
			end
			KIND_QUAD_STRIP: begin
				if (keep_quads) begin
					emit_qstrip = pos_ge3 && pos_q[0];
				end else begin
					emit_strip = pos_ge2;
				end
			end
			KIND_TRI_STRIP: begin
				emit_strip = pos_ge2;
			end
			default: begin
				emit_single = 1'b1;
			end
		endcase
	end

	// Build the job: its kind, its vertex count and its vertices in order.
	always_comb begin
		job_valid = emit_single || emit_fan || emit_strip || emit_qstrip;
		job_ctl   = '{kind: KIND_TRI, n: NVERT_W'(3), eop_last: 1'b1};
		job_verts = {SLOTS{vertex}};
		priority if (emit_single) begin
			job_ctl = '{kind: single_kind, n: NVERT_W'(1), eop_last: is_end};
		end else if (emit_fan) begin
			job_verts[0] = first;
			job_verts[1] = prev_one_q;
			job_verts[2] = vertex;
		end else if (emit_strip) begin
			job_verts[0] = prev_two_q;
			// Odd positions reverse the winding.
			job_verts[1] = pos_q[0] ? vertex : prev_one_q;
			job_verts[2] = pos_q[0] ? prev_one_q : vertex;
		end else begin
			job_ctl      = '{kind: KIND_QUAD, n: NVERT_W'(SLOTS), eop_last: 1'b1};
			job_verts[0] = prev_three_q;
			job_verts[1] = prev_two_q;
			job_verts[2] = vertex;
			job_verts[3] = prev_one_q;
		end
	end

	// Position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= is_end ? '0 : pos_inc[COUNT_WIDTH-1:0];
		end
	end

	// Vertex history.
	always_ff @(posedge clk) begin
		if (accept) begin
			first_q      <= first;
			prev_three_q <= prev_two_q;
			prev_two_q   <= prev_one_q;
			prev_one_q   <= vertex;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/ptd_queue.sv -----
`default_nettype none

module ptd_queue
	import ptd_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output logic [WIDTH-1:0]      head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ----- hdl/ptd_back.sv -----
`default_nettype none

module ptd_back
	import ptd_pkg::*;
#(
	parameter int VERTEX_WIDTH = VERTEX_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               head_valid,
	input  wire job_ctl_t                           head_ctl,
	input  wire logic [SLOTS-1:0][VERTEX_WIDTH-1:0] head_verts,
	output logic                                    pop,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [VERTEX_WIDTH-1:0]                 out_vertex,
	output logic [KIND_W-1:0]                       out_kind,
	output logic                                    out_eop,
	output logic                                    out_last
);

	logic [SLOT_W-1:0]       idx_q;
	logic                    out_valid_q;
	logic [VERTEX_WIDTH-1:0] out_vertex_q;
	logic [KIND_W-1:0]       out_kind_q;
	logic                    out_eop_q;
	logic                    out_last_q;

	logic                    slot_free;
	logic                    load;
	logic                    is_last;

	// One vertex of the head job moves to the output register per cycle while that register is free.
	always_comb begin
		slot_free = !out_valid_q || out_ready;
		load      = head_valid && slot_free;
		is_last   = (NVERT_W'(idx_q) + NVERT_W'(1)) == head_ctl.n;
		pop       = load && is_last;
	end

	// Slot index within the head job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= is_last ? '0 : idx_q + SLOT_W'(1);
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= head_valid;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			out_vertex_q <= head_verts[idx_q];
			out_kind_q   <= head_ctl.kind;
			out_eop_q    <= is_last && head_ctl.eop_last;
			out_last_q   <= is_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_vertex = out_vertex_q;
	assign out_kind   = out_kind_q;
	assign out_eop    = out_eop_q;
	assign out_last   = out_last_q;

`ifndef SYNTHESIS
	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (NVERT_W'(idx_q) < head_ctl.n))
		else $error("slot index beyond the job's vertex count");
	a_eop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_eop_q) |-> out_last_q)
		else $error("end of primitive before the last vertex of a job");
`endif

endmodule

`default_nettype wire

// ----- hdl/primitive_topology_decompose_unit.sv -----
`default_nettype none

// Primitive topology decomposer: turns per-vertex primitive commands into a
// stream of separate triangles, quads or passed-through vertices.
//
// Input stream: one vertex per transfer; tuser carries the command kind and
// tdata the vertex payload and the command's vertex count. Output stream: one
// emitted vertex per transfer; tuser carries the primitive kind and the
// end-of-primitive flag, tlast marks the final vertex caused by one input.
// The cfg channel writes max_valence; it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
//
// An accepted item's job is written into the job queue, and its vertices then pass
// from the queue head through the output register. An item makes zero to four
// output transfers, and the output register issues one per cycle while m_tready
// is high. A two-entry job queue lets input continue while the output is
// stalled; when it is full, s_tready drops. Reset clears the position
// counter, the queue and the output valid, and sets max_valence to 4.
module primitive_topology_decompose_unit
	import ptd_pkg::*;
#(
	parameter int VERTEX_WIDTH = VERTEX_WIDTH_DEF,
	parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	// Configuration write: max_valence.
	input  wire logic                                          cfg_valid,
	output logic                                               cfg_ready,
	input  wire logic [VALENCE_W-1:0]                          cfg_data,
	// Input stream.
	input  wire logic                                          s_tvalid,
	output logic                                               s_tready,
	// tdata from bit 0: vertex, vertex_count, zero fill.
	input  wire logic [((VERTEX_WIDTH+COUNT_WIDTH+7)/8)*8-1:0] s_tdata,
	// tuser: cmd.
	input  wire logic [KIND_W-1:0]                             s_tuser,
	// Output stream.
	output logic                                               m_tvalid,
	input  wire logic                                          m_tready,
	// tdata from bit 0: out_vertex, zero fill.
	output logic [((VERTEX_WIDTH+7)/8)*8-1:0]                  m_tdata,
	// tuser from bit 0: out_kind, end_of_primitive.
	output logic [OUT_TUSER_W-1:0]                             m_tuser,
	output logic                                               m_tlast
);

	localparam int OUT_TDATA_W = ((VERTEX_WIDTH + 7) / 8) * 8;
	localparam int JOB_W       = CTL_W + SLOTS * VERTEX_WIDTH;

	logic                               accept;
	logic                               job_valid;
	job_ctl_t                           job_ctl;
	logic [SLOTS-1:0][VERTEX_WIDTH-1:0] job_verts;
	logic                               queue_full;
	logic                               head_valid;
	logic [JOB_W-1:0]                   head_data;
	job_ctl_t                           head_ctl;
	logic [SLOTS-1:0][VERTEX_WIDTH-1:0] head_verts;
	logic                               pop;
	logic [VERTEX_WIDTH-1:0]            out_vertex;
	logic [KIND_W-1:0]                  out_kind;
	logic                               out_eop;

	// An item is taken whenever the queue has room for its job.
	assign s_tready = !queue_full;
	assign accept   = s_tvalid && s_tready;

	ptd_front #(
		.VERTEX_WIDTH(VERTEX_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.cmd         (s_tuser),
		.vertex      (s_tdata[VERTEX_WIDTH-1:0]),
		.vertex_count(s_tdata[VERTEX_WIDTH+COUNT_WIDTH-1:VERTEX_WIDTH]),
		.job_valid   (job_valid),
		.job_ctl     (job_ctl),
		.job_verts   (job_verts)
	);

	ptd_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && job_valid),
		.push_data ({job_verts, job_ctl}),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	// Split the head entry back into control and vertices.
	assign head_ctl   = head_data[CTL_W-1:0];
	assign head_verts = head_data[JOB_W-1:CTL_W];

	ptd_back #(
		.VERTEX_WIDTH(VERTEX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_ctl  (head_ctl),
		.head_verts(head_verts),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_vertex(out_vertex),
		.out_kind  (out_kind),
		.out_eop   (out_eop),
		.out_last  (m_tlast)
	);

	assign m_tdata = OUT_TDATA_W'(out_vertex);
	assign m_tuser = {out_eop, out_kind};

endmodule

`default_nettype wire

// ----- verif/tb_primitive_topology_decompose_unit.sv -----
`default_nettype none

module tb_primitive_topology_decompose_unit;
	import ptd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int VW = 64;
	localparam int CW = 16;
	localparam int S_DATA_W = ((VW + CW + 7) / 8) * 8;
	localparam int M_DATA_W = ((VW + 7) / 8) * 8;

	// Cycles to let a vertex that emits nothing clear the pipeline.
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AT = 100;
	localparam int PHASE_ITEMS = 27;

	// Highest kind code on the four-bit field; codes above other pass through.
	localparam logic [KIND_W-1:0] KIND_CODE_MAX = '1;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [VW-1:0]     vertex;
		logic [CW-1:0]     count;
	} feed_item_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [VW-1:0]     vertex;
		logic              eop;
		logic              last;
	} emitted_vert_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [VALENCE_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic [KIND_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic m_tlast;

	primitive_topology_decompose_unit #(
		.VERTEX_WIDTH(VW),
		.COUNT_WIDTH (CW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	feed_item_t vertex_feed[$];
	emitted_vert_t emitted_verts[$];
	feed_item_t next_item;

	// Shadow copy of the decomposer state and its valence register.
	logic [VALENCE_W-1:0] valence = VALENCE_RESET;
	logic [VW-1:0] fan_root_q = '0;
	logic [VW-1:0] prev1_q = '0;
	logic [VW-1:0] prev2_q = '0;
	logic [VW-1:0] prev3_q = '0;
	logic [CW-1:0] vert_pos_q = '0;

	logic quiet = 1'b0;
	int errors = 0;
	int inputs_accepted = 0;
	int results_checked = 0;
	int valence_writes = 0;
	int cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	task automatic emit(input logic [KIND_W-1:0] kind, input logic [VW-1:0] vtx,
			input logic eop);
		emitted_vert_t e;
		e.kind = kind;
		e.vertex = vtx;
		e.eop = eop;
		e.last = 1'b0;
		emitted_verts.insert(emitted_verts.size(), e);
	endtask

	task automatic emit_tri(input logic [VW-1:0] a, input logic [VW-1:0] b,
			input logic [VW-1:0] c);
		emit(KIND_TRI, a, 1'b0);
		emit(KIND_TRI, b, 1'b0);
		emit(KIND_TRI, c, 1'b1);
	endtask

	// Works out the vertices that one accepted input vertex produces.
	task automatic decompose_vertex(input logic [KIND_W-1:0] cmd, input logic [VW-1:0] vtx,
			input logic [CW-1:0] cnt);
		logic [CW:0] next_pos;
		logic at_end;
		logic keep_quads;
		logic [VW-1:0] fan_root;
		int base;
		emitted_vert_t tail;
		next_pos = {1'b0, vert_pos_q} + 1'b1;
		at_end = next_pos >= {1'b0, cnt};
		keep_quads = valence > VALENCE_TRI_MAX;
		fan_root = (vert_pos_q == '0) ? vtx : fan_root_q;
		base = emitted_verts.size();
		case (cmd)
			KIND_QUAD, KIND_QUAD_HARD, KIND_SMOKE_BLACK, KIND_SMOKE_WHITE, KIND_MOVIE: begin
				if (keep_quads)
					emit(KIND_QUAD, vtx, at_end);
				else if (vert_pos_q == 2 || vert_pos_q == 3)
					emit_tri(fan_root, prev1_q, vtx);
			end
			KIND_POLYGON: begin
				if ({{(CW-VALENCE_W){1'b0}}, valence} < cnt) begin
					if (vert_pos_q >= 2)
						emit_tri(fan_root, prev1_q, vtx);
				end else begin
					emit(KIND_POLYGON, vtx, at_end);
				end
			end
			KIND_TRI_FAN: begin
				if (vert_pos_q >= 2)
					emit_tri(fan_root, prev1_q, vtx);
			end
			KIND_TRI_STRIP, KIND_QUAD_STRIP: begin
				if (cmd == KIND_QUAD_STRIP && keep_quads) begin
					if (vert_pos_q >= 3 && vert_pos_q[0]) begin
						emit(KIND_QUAD, prev3_q, 1'b0);
						emit(KIND_QUAD, prev2_q, 1'b0);
						emit(KIND_QUAD, vtx, 1'b0);
						emit(KIND_QUAD, prev1_q, 1'b1);
					end
				end else if (vert_pos_q >= 2) begin
					// Odd positions flip the winding.
					if (vert_pos_q[0])
						emit_tri(prev2_q, vtx, prev1_q);
					else
						emit_tri(prev2_q, prev1_q, vtx);
				end
			end
			default: begin
				emit(cmd, vtx, at_end);
			end
		endcase
		if (emitted_verts.size() > base) begin
			tail = emitted_verts[emitted_verts.size() - 1];
			tail.last = 1'b1;
			emitted_verts[emitted_verts.size() - 1] = tail;
		end
		fan_root_q = fan_root;
		prev3_q = prev2_q;
		prev2_q = prev1_q;
		prev1_q = vtx;
		vert_pos_q = at_end ? '0 : next_pos[CW-1:0];
	endtask

	task automatic queue_item(input logic [KIND_W-1:0] kind, input logic [VW-1:0] vtx,
			input logic [CW-1:0] cnt);
		feed_item_t it;
		it.kind = kind;
		it.vertex = vtx;
		it.count = cnt;
		vertex_feed.insert(vertex_feed.size(), it);
	endtask

	// Queues the first n vertices of a command with random payloads.
	task automatic push_command(input logic [KIND_W-1:0] kind, input logic [CW-1:0] cnt,
			input int n);
		for (int i = 0; i < n; i++)
			queue_item(kind, {$urandom, $urandom}, cnt);
	endtask

	// Mostly complete commands, with lone vertices and cut-off commands mixed in.
	task automatic push_random_mix(input int target);
		int queued;
		int r;
		logic [KIND_W-1:0] kind;
		int cnt;
		queued = 0;
		while (queued < target) begin
			r = $urandom_range(0, 99);
			kind = ($urandom_range(0, 99) < 88)
				? KIND_W'($urandom_range(KIND_TRI, KIND_OTHER))
				: KIND_W'($urandom_range(KIND_OTHER + 1, KIND_CODE_MAX));
			if (r < 80) begin
				case (kind)
					KIND_QUAD, KIND_QUAD_HARD, KIND_SMOKE_BLACK, KIND_SMOKE_WHITE, KIND_MOVIE:
						cnt = ($urandom_range(0, 3) != 0) ? 4 : $urandom_range(1, 6);
					KIND_QUAD_STRIP:
						cnt = ($urandom_range(0, 3) != 0) ? 2 * $urandom_range(1, 5)
							: $urandom_range(1, 9);
					KIND_POLYGON:
						cnt = $urandom_range(3, 8);
					default:
						cnt = $urandom_range(1, 7);
				endcase
				push_command(kind, CW'(cnt), cnt);
				queued += cnt;
			end else if (r < 90) begin
				queue_item(kind, {$urandom, $urandom}, CW'($urandom_range(0, 65535)));
				queued += 1;
			end else begin
				cnt = $urandom_range(3, 8);
				r = $urandom_range(1, cnt - 1);
				push_command(kind, CW'(cnt), r);
				queued += r;
			end
		end
	endtask

	task automatic wait_idle();
		while (vertex_feed.size() != 0 || s_tvalid || emitted_verts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_valence(input logic [VALENCE_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Input side: records each transfer in the shadow model and offers the next vertex.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				valence = cfg_data;
				valence_writes++;
			end
			if (s_tvalid && s_tready) begin
				decompose_vertex(s_tuser, s_tdata[VW-1:0], s_tdata[VW+CW-1:VW]);
				inputs_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (vertex_feed.size() != 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
					next_item = vertex_feed.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{(S_DATA_W-VW-CW){1'b0}}, next_item.count, next_item.vertex};
					s_tuser <= next_item.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side readiness, with one long hold so the job queue backs up.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (!hold_done && inputs_accepted >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(0, 99) >= 6);
			end
		end
	end

	// Compares every output transfer with the oldest predicted vertex.
	always @(posedge clk) begin
		emitted_vert_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (emitted_verts.size() == 0) begin
				$error("unexpected output vertex %h kind %0d", m_tdata[VW-1:0],
					m_tuser[KIND_W-1:0]);
				errors++;
			end else begin
				want = emitted_verts.pop_front();
				results_checked++;
				if (m_tuser[KIND_W-1:0] !== want.kind) begin
					$error("out_kind: expected %0d, got %0d", want.kind, m_tuser[KIND_W-1:0]);
					errors++;
				end
				if (m_tdata[VW-1:0] !== want.vertex) begin
					$error("out_vertex: expected %h, got %h", want.vertex, m_tdata[VW-1:0]);
					errors++;
				end
				if (m_tuser[EOP_BIT] !== want.eop) begin
					$error("end_of_primitive: expected %0d, got %0d", want.eop,
						m_tuser[EOP_BIT]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d vertices still expected.",
				cycles, emitted_verts.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [VALENCE_W-1:0] plan [5];
		plan[0] = 8'd3;
		plan[1] = 8'd0;
		plan[2] = 8'd255;
		plan[3] = 8'd4;
		plan[4] = VALENCE_W'($urandom_range(0, 255));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset valence, which keeps quads.
		queue_item(KIND_TRI, '0, 16'd3);
		queue_item(KIND_TRI, '1, 16'd3);
		queue_item(KIND_TRI, {$urandom, $urandom}, 16'd3);
		push_command(KIND_QUAD, 16'd4, 4);
		push_command(KIND_POLYGON, 16'd4, 4);
		push_command(KIND_TRI_FAN, 16'd3, 3);
		// Quad strip with an odd trailing vertex.
		push_command(KIND_QUAD_STRIP, 16'd5, 5);
		push_command(KIND_TRI_STRIP, 16'd4, 4);
		// A zero count behaves as a one-vertex command.
		queue_item(KIND_OTHER, {$urandom, $urandom}, 16'd0);
		queue_item(KIND_CODE_MAX, '1, 16'hFFFF);
		queue_item(KIND_MOVIE, {$urandom, $urandom}, 16'd1);
		wait_idle();

		// Random phases, one valence setting each; the second runs without idling.
		for (int ph = 0; ph < 5; ph++) begin
			write_valence(plan[ph]);
			quiet <= (ph == 1);
			push_random_mix(PHASE_ITEMS);
			wait_idle();
		end
		quiet <= 1'b0;

		$display("Run covered %0d input vertices and %0d checked output vertices", inputs_accepted,
			results_checked);
		$display("over %0d valence writes and a %0d-cycle output hold.", valence_writes,
			HOLD_CYCLES);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire
